FILE: rtl/x86rel_pkg.sv
package x86rel_pkg;

   // Field widths
   localparam int unsigned ADDR_W     = 64;
   localparam int unsigned TYPE_W     = 8;
   localparam int unsigned IDX_W      = 16;
   localparam int unsigned BYTES_W    = 4;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam int unsigned DEF_GOT_ENTRY_BYTES = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GOT_BASE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOT_MAX  = 1'b1;

   // ELF x86-64 relocation types handled
   localparam logic [TYPE_W-1:0] R_NONE          = 8'd0;
   localparam logic [TYPE_W-1:0] R_64            = 8'd1;
   localparam logic [TYPE_W-1:0] R_PC32          = 8'd2;
   localparam logic [TYPE_W-1:0] R_PLT32         = 8'd4;
   localparam logic [TYPE_W-1:0] R_32            = 8'd10;
   localparam logic [TYPE_W-1:0] R_32S           = 8'd11;
   localparam logic [TYPE_W-1:0] R_PC64          = 8'd24;
   localparam logic [TYPE_W-1:0] R_GOTPCRELX     = 8'd41;
   localparam logic [TYPE_W-1:0] R_REX_GOTPCRELX = 8'd42;

   // Patch widths
   localparam logic [BYTES_W-1:0] WB_NONE = 4'd0;
   localparam logic [BYTES_W-1:0] WB_4    = 4'd4;
   localparam logic [BYTES_W-1:0] WB_8    = 4'd8;

   localparam logic [31:0] LOW32 = 32'hffff_ffff;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NONZERO  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_UNKNOWN  = 2'd3
   } status_type;

   typedef struct packed {
      logic [TYPE_W-1:0]        reloc_type;
      logic [ADDR_W-1:0]        symbol_value;
      logic signed [ADDR_W-1:0] addend;
      logic [ADDR_W-1:0]        existing_contents;
      logic [ADDR_W-1:0]        place_address;
      logic                     symbol_is_section;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BYTES_W-1:0]  write_bytes;
      logic [ADDR_W-1:0]   write_value;
      logic                got_written;
      logic [IDX_W-1:0]    got_index;
      logic [ADDR_W-1:0]   got_target;
   } result_type;

   // GOT allocator state seen by the datapath
   typedef struct packed {
      logic [IDX_W-1:0]  count;
      logic              full;
      logic [ADDR_W-1:0] entry_addr;
   } got_state_type;

endpackage

FILE: rtl/x86_64_relocation_applier_unit.sv
// x86-64 RELA relocation applier.
//
// Request channel (req_*): one RELA entry per transaction, with type, symbol
// value S, addend A, the eight bytes now at the patch place and the place
// address P. Response channel (rsp_*): one transaction per request, giving
// status, byte count and value to patch, plus GOT entry info when one of the
// GOTPCRELX types allocated a table entry.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low.
// CSR port: csr_index 0 = GOT base address, 1 = GOT entry count limit.
// Write only while the unit is idle.
// The response is registered: a request passes the input register, then the
// result register, before rsp_valid rises. Throughput: one transaction per
// cycle while the response is not stalled, set by the combinational
// add/subtract path and the GOT counter update.
// Stall: a stalled response holds; the input register keeps accepting until
// it holds an entry that cannot move, then req_stall rises.
// Reset (synchronous): pipeline empty, GOT counter, base and limit cleared.
module x86_64_relocation_applier_unit #(
   parameter int unsigned GOT_ENTRY_BYTES = x86rel_pkg::DEF_GOT_ENTRY_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write_enable,
   input  logic [x86rel_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [x86rel_pkg::ADDR_W-1:0]       csr_write_data,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [x86rel_pkg::TYPE_W-1:0]       req_reloc_type,
   input  logic [x86rel_pkg::ADDR_W-1:0]       req_symbol_value,
   input  logic signed [x86rel_pkg::ADDR_W-1:0] req_addend,
   input  logic [x86rel_pkg::ADDR_W-1:0]       req_existing_contents,
   input  logic [x86rel_pkg::ADDR_W-1:0]       req_place_address,
   input  logic                                req_symbol_is_section,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [x86rel_pkg::BYTES_W-1:0]      rsp_write_bytes,
   output logic [x86rel_pkg::ADDR_W-1:0]       rsp_write_value,
   output logic                                rsp_got_written,
   output logic [x86rel_pkg::IDX_W-1:0]        rsp_got_index,
   output logic [x86rel_pkg::ADDR_W-1:0]       rsp_got_target
);

   // input stage
   logic                      s1_valid_ff, s1_valid_in;
   x86rel_pkg::req_type       s1_ff;
   // result stage
   logic                      rsp_valid_ff, rsp_valid_in;
   x86rel_pkg::result_type    rsp_ff;

   x86rel_pkg::result_type    calc_res;
   x86rel_pkg::got_state_type got_state;

   logic out_free;   // result register can take a new entry this cycle
   logic s1_move;    // input register entry moves to result register
   logic req_take;   // request transaction completes
   logic alloc;      // GOT entry consumed this cycle

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   // counter only advances when the allocating entry actually leaves stage 1,
   // so a stalled entry keeps seeing its own index
   assign alloc     = s1_move && calc_res.got_written;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   x86rel_got #(
      .GOT_ENTRY_BYTES (GOT_ENTRY_BYTES)
   ) u_got (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .alloc            (alloc),
      .got_state        (got_state)
   );

   x86rel_calc u_calc (
      .req       (s1_ff),
      .got_state (got_state),
      .res       (calc_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff.reloc_type        <= req_reloc_type;
         s1_ff.symbol_value      <= req_symbol_value;
         s1_ff.addend            <= req_addend;
         s1_ff.existing_contents <= req_existing_contents;
         s1_ff.place_address     <= req_place_address;
         s1_ff.symbol_is_section <= req_symbol_is_section;
      end
      if (s1_move) begin
         rsp_ff <= calc_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_write_bytes = rsp_ff.write_bytes;
   assign rsp_write_value = rsp_ff.write_value;
   assign rsp_got_written = rsp_ff.got_written;
   assign rsp_got_index   = rsp_ff.got_index;
   assign rsp_got_target  = rsp_ff.got_target;

   // allocation bumps the table counter by exactly one
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      alloc |=> (got_state.count == x86rel_pkg::IDX_W'($past(got_state.count) + 1'b1)))
      else $error("GOT counter did not advance on allocation");

   // an allocated entry is only reported with ok or nonzero-target status
   a_alloc_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_got_written) |->
         (rsp_status == x86rel_pkg::ST_OK || rsp_status == x86rel_pkg::ST_NONZERO))
      else $error("GOT allocation reported with bad status");

   // nothing to write means a zero value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_bytes == x86rel_pkg::WB_NONE) |-> (rsp_write_value == '0))
      else $error("write value nonzero with no bytes to write");

   // a full pipeline under output stall must push back on requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request accepted while pipeline is blocked");

endmodule

FILE: rtl/x86rel_got.sv
module x86rel_got #(
   parameter int unsigned GOT_ENTRY_BYTES = x86rel_pkg::DEF_GOT_ENTRY_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [x86rel_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [x86rel_pkg::ADDR_W-1:0]       csr_write_data,
   input  logic                                alloc,
   output x86rel_pkg::got_state_type           got_state
);

   localparam int unsigned EB_W   = $clog2(GOT_ENTRY_BYTES + 1);
   localparam int unsigned PROD_W = x86rel_pkg::IDX_W + EB_W;

   logic [x86rel_pkg::IDX_W-1:0]  count_ff, count_in;
   logic [x86rel_pkg::IDX_W-1:0]  max_ff, max_in;
   logic [x86rel_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [PROD_W-1:0]             offset;

   // offset of the next free entry from the table base
   assign offset = PROD_W'(count_ff) * PROD_W'(GOT_ENTRY_BYTES);

   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      addr_in  = addr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            x86rel_pkg::CSR_GOT_BASE: begin
               addr_in = csr_write_data + x86rel_pkg::ADDR_W'(offset);
            end
            x86rel_pkg::CSR_GOT_MAX: begin
               max_in = csr_write_data[x86rel_pkg::IDX_W-1:0];
            end
            default: ;
         endcase
      end else if (alloc) begin
         count_in = count_ff + 1'b1;
         addr_in  = addr_ff + x86rel_pkg::ADDR_W'(GOT_ENTRY_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         addr_ff  <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         addr_ff  <= addr_in;
      end
   end

   assign got_state.count      = count_ff;
   assign got_state.full       = (count_ff >= max_ff);
   assign got_state.entry_addr = addr_ff;

endmodule

FILE: rtl/x86rel_calc.sv
module x86rel_calc (
   input  x86rel_pkg::req_type        req,
   input  x86rel_pkg::got_state_type  got_state,
   output x86rel_pkg::result_type     res
);

   logic                          is_got;
   logic [x86rel_pkg::ADDR_W-1:0] base_op;
   logic [x86rel_pkg::ADDR_W-1:0] sum;
   logic [x86rel_pkg::ADDR_W-1:0] diff;
   logic                          cur_any;
   logic                          cur_low;
   logic                          fit32;
   logic                          fit32s;

   assign is_got  = (req.reloc_type == x86rel_pkg::R_GOTPCRELX) ||
                    (req.reloc_type == x86rel_pkg::R_REX_GOTPCRELX);
   // GOT types relocate against the entry address, others against S
   assign base_op = is_got ? got_state.entry_addr : req.symbol_value;
   assign sum     = base_op + $unsigned(req.addend);
   assign diff    = sum - req.place_address;
   assign cur_any = |req.existing_contents;
   assign cur_low = |req.existing_contents[31:0];
   assign fit32   = ~|sum[63:32];
   assign fit32s  = (sum[63:32] == {32{sum[31]}});

   always_comb begin
      res             = '0;
      res.status      = x86rel_pkg::ST_OK;
      unique case (req.reloc_type)
         x86rel_pkg::R_NONE: ;
         x86rel_pkg::R_64, x86rel_pkg::R_PC64: begin
            if (cur_any) begin
               res.status = x86rel_pkg::ST_NONZERO;
            end else begin
               res.write_bytes = x86rel_pkg::WB_8;
               res.write_value = (req.reloc_type == x86rel_pkg::R_PC64) ? diff : sum;
            end
         end
         x86rel_pkg::R_32, x86rel_pkg::R_32S: begin
            if (cur_low) begin
               res.status = x86rel_pkg::ST_NONZERO;
            end else begin
               res.write_bytes = x86rel_pkg::WB_4;
               res.write_value = {32'd0, sum[31:0]};
               if (!req.symbol_is_section &&
                   !((req.reloc_type == x86rel_pkg::R_32) ? fit32 : fit32s)) begin
                  res.status = x86rel_pkg::ST_OVERFLOW;
               end
            end
         end
         x86rel_pkg::R_GOTPCRELX, x86rel_pkg::R_REX_GOTPCRELX: begin
            if (got_state.full) begin
               res.status = x86rel_pkg::ST_OVERFLOW;
            end else begin
               // entry is taken even if the place turns out dirty
               res.got_written = 1'b1;
               res.got_index   = got_state.count;
               res.got_target  = req.symbol_value;
               if (cur_low) begin
                  res.status = x86rel_pkg::ST_NONZERO;
               end else begin
                  res.write_bytes = x86rel_pkg::WB_4;
                  res.write_value = {32'd0, diff[31:0] & x86rel_pkg::LOW32};
               end
            end
         end
         x86rel_pkg::R_PC32, x86rel_pkg::R_PLT32: begin
            if (cur_low) begin
               res.status = x86rel_pkg::ST_NONZERO;
            end else begin
               res.write_bytes = x86rel_pkg::WB_4;
               res.write_value = {32'd0, diff[31:0]};
            end
         end
         default: begin
            res.status = x86rel_pkg::ST_UNKNOWN;
         end
      endcase
   end

endmodule
